// ===== rtl/hbcic_pkg.sv =====
// Shared constants for the half-band / CIC3 decimate-by-2 stage.
// Used by halfband_cic_decimate_by2; depends on nothing else.
`default_nettype none

package hbcic_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 18;

  localparam int NUM_COEFS   = 7;
  localparam int HIST_DEPTH  = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int COEF_IDX_W  = 3;

  // Position of the center coefficient in the coefficient bank.
  localparam int COEF_CENTER_IDX = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_MODE = 3'd0,
    REG_COEF_TAP0   = 3'd1,
    REG_COEF_TAP2   = 3'd2,
    REG_COEF_TAP4   = 3'd3,
    REG_COEF_CENTER = 3'd4,
    REG_COEF_TAP6   = 3'd5,
    REG_COEF_TAP8   = 3'd6,
    REG_COEF_TAP10  = 3'd7
  } reg_index_t;

  localparam logic MODE_HALFBAND = 1'b0;
  localparam logic MODE_CIC3     = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/halfband_cic_decimate_by2.sv =====
// Complex I/Q decimate-by-2 stage: 11-tap half-band FIR or third-order CIC.
// Depends on hbcic_pkg for parameter defaults, register indexes and mode codes.
//
// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid / s_tready     s_tdata: sample_i, sample_q
// m_*       out  m_tvalid / m_tready     m_tdata: out_i, out_q
// cfg_*     in   cfg_wen                 cfg_index, cfg_data
//
// One input item can be accepted every cycle; the sample history and phase
// advance at acceptance. An item that produces a result passes the operand
// register, product register, accumulator register and the rounded, saturated
// output register before m_tvalid. Each stage advances independently, so the
// block keeps accepting while a result waits until all four stages are full.
// Reset clears the history, the phase, the configuration and all valid bits.
`default_nettype none

module halfband_cic_decimate_by2 #(
  parameter int SAMPLE_WIDTH = hbcic_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = hbcic_pkg::COEF_WIDTH_DEF,
  localparam int TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // Fields from bit 0 up: sample_i, sample_q, zero padding.
  input  wire logic [TDATA_W-1:0]                   s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // Fields from bit 0 up: out_i, out_q, zero padding.
  output logic [TDATA_W-1:0]                        m_tdata,
  input  wire logic                                 cfg_wen,
  input  wire logic [hbcic_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [COEF_WIDTH-1:0]                cfg_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COEF_WIDTH;
  localparam int NC   = hbcic_pkg::NUM_COEFS;
  localparam int HD   = hbcic_pkg::HIST_DEPTH;
  localparam int PW   = SW + CW;
  localparam int AW   = PW + 4;
  localparam int CSW  = SW + 4;
  localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
  localparam logic signed [AW-1:0] FIR_RND = AW'(64'sd1 <<< (CW - 2));
  localparam logic signed [AW-1:0] CIC_RND = AW'(4);

  // Configuration registers.
  logic                 mode;
  logic signed [CW-1:0] coef [NC];

  // History: hist_*[k] holds x[m-1-k].
  logic signed [SW-1:0] hist_i [HD];
  logic signed [SW-1:0] hist_q [HD];
  logic                 phase;

  logic signed [SW-1:0] in_i, in_q;
  logic                 accept, emit;

  // Pipeline stage registers.
  logic                  v1, v2, v3;
  logic                  cic1, cic2, cic3;
  logic signed [SW-1:0]  op_i [NC];
  logic signed [SW-1:0]  op_q [NC];
  logic signed [SW-1:0]  op_i_next [NC];
  logic signed [SW-1:0]  op_q_next [NC];
  logic signed [PW-1:0]  prod_i [NC];
  logic signed [PW-1:0]  prod_q [NC];
  logic signed [CSW-1:0] cic_i, cic_q;
  logic signed [CSW-1:0] cic_i_next, cic_q_next;
  logic signed [AW-1:0]  acc_i, acc_q;
  logic signed [AW-1:0]  acc_i_next, acc_q_next;
  logic signed [AW-1:0]  sh_i, sh_q;
  logic signed [SW-1:0]  sat_i, sat_q;
  logic signed [SW-1:0]  out_i, out_q;

  logic en1, en2, en3, en4;

  assign in_i = s_tdata[SW-1:0];
  assign in_q = s_tdata[2*SW-1:SW];

  // Each stage loads when the one after it can take its contents.
  assign en4      = !m_tvalid || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign accept   = s_tvalid && s_tready;

  // Half-band emits on even inputs, CIC3 on odd ones.
  assign emit = (mode == hbcic_pkg::MODE_HALFBAND) ? (phase == 1'b0) : (phase == 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hbcic_pkg::MODE_HALFBAND;
      for (int n = 0; n < NC; n++) begin
        if (n == hbcic_pkg::COEF_CENTER_IDX) begin
          coef[n] <= CW'(1) << (CW - 2);
        end else begin
          coef[n] <= '0;
        end
      end
    end else if (cfg_wen) begin
      case (cfg_index)
        hbcic_pkg::REG_FILTER_MODE: mode <= cfg_data[0];
        default: coef[hbcic_pkg::COEF_IDX_W'(cfg_index - 3'd1)] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      for (int k = 0; k < HD; k++) begin
        hist_i[k] <= '0;
        hist_q[k] <= '0;
      end
    end else if (accept) begin
      phase <= ~phase;
      hist_i[0] <= in_i;
      hist_q[0] <= in_q;
      for (int k = 1; k < HD; k++) begin
        hist_i[k] <= hist_i[k-1];
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // Operand selection. FIR taps are x[m-10], x[m-8], x[m-6], x[m-5], x[m-4],
  // x[m-2] and x[m]. CIC uses the current odd sample, the even one before it,
  // the previous odd one and the previous even one.
  always_comb begin
    for (int n = 0; n < NC; n++) begin
      op_i_next[n] = '0;
      op_q_next[n] = '0;
    end
    if (mode == hbcic_pkg::MODE_CIC3) begin
      op_i_next[0] = in_i;      op_q_next[0] = in_q;
      op_i_next[1] = hist_i[2]; op_q_next[1] = hist_q[2];
      op_i_next[2] = hist_i[1]; op_q_next[2] = hist_q[1];
      op_i_next[3] = hist_i[0]; op_q_next[3] = hist_q[0];
    end else begin
      op_i_next[0] = hist_i[9]; op_q_next[0] = hist_q[9];
      op_i_next[1] = hist_i[7]; op_q_next[1] = hist_q[7];
      op_i_next[2] = hist_i[5]; op_q_next[2] = hist_q[5];
      op_i_next[3] = hist_i[4]; op_q_next[3] = hist_q[4];
      op_i_next[4] = hist_i[3]; op_q_next[4] = hist_q[3];
      op_i_next[5] = hist_i[1]; op_q_next[5] = hist_q[1];
      op_i_next[6] = in_i;      op_q_next[6] = in_q;
    end
  end

  // Stage 1: operand register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cic1 <= (mode == hbcic_pkg::MODE_CIC3);
      for (int n = 0; n < NC; n++) begin
        op_i[n] <= op_i_next[n];
        op_q[n] <= op_q_next[n];
      end
    end
  end

  // Stage 2: one multiplier per tap and lane, plus the CIC weighted sum.
  always_comb begin
    cic_i_next = CSW'(op_i[0]) + CSW'(op_i[1])
               + ((CSW'(op_i[2]) + CSW'(op_i[3])) <<< 1) + CSW'(op_i[2]) + CSW'(op_i[3]);
    cic_q_next = CSW'(op_q[0]) + CSW'(op_q[1])
               + ((CSW'(op_q[2]) + CSW'(op_q[3])) <<< 1) + CSW'(op_q[2]) + CSW'(op_q[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cic2  <= cic1;
      cic_i <= cic_i_next;
      cic_q <= cic_q_next;
      for (int n = 0; n < NC; n++) begin
        prod_i[n] <= PW'(op_i[n]) * PW'(coef[n]);
        prod_q[n] <= PW'(op_q[n]) * PW'(coef[n]);
      end
    end
  end

  // Stage 3: sum of products, or the CIC weighted sum, with the rounding offset already added.
  always_comb begin
    if (cic2) begin
      acc_i_next = AW'(cic_i) + CIC_RND;
      acc_q_next = AW'(cic_q) + CIC_RND;
    end else begin
      acc_i_next = FIR_RND;
      acc_q_next = FIR_RND;
      for (int n = 0; n < NC; n++) begin
        acc_i_next = acc_i_next + AW'(prod_i[n]);
        acc_q_next = acc_q_next + AW'(prod_q[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cic3  <= cic2;
      acc_i <= acc_i_next;
      acc_q <= acc_q_next;
    end
  end

  // Stage 4: scale back and saturate into the output register.
  always_comb begin
    sh_i = cic3 ? (acc_i >>> 3) : (acc_i >>> (CW - 1));
    sh_q = cic3 ? (acc_q >>> 3) : (acc_q >>> (CW - 1));
    if (sh_i > SAT_HI) begin
      sat_i = SW'(SAT_HI);
    end else if (sh_i < SAT_LO) begin
      sat_i = SW'(SAT_LO);
    end else begin
      sat_i = sh_i[SW-1:0];
    end
    if (sh_q > SAT_HI) begin
      sat_q = SW'(SAT_HI);
    end else if (sh_q < SAT_LO) begin
      sat_q = SW'(SAT_LO);
    end else begin
      sat_q = sh_q[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_i <= sat_i;
      out_q <= sat_q;
    end
  end

  generate
    if (TDATA_W > 2 * SW) begin : g_pad
      assign m_tdata = {{(TDATA_W - 2 * SW){1'b0}}, out_q, out_i};
    end else begin : g_nopad
      assign m_tdata = {out_q, out_i};
    end
  endgenerate

  // An accepted item enters the pipeline exactly when the mode matches the phase.
  a_emit_on_match: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == phase)) |=> v1)
    else $error("accepted item with matching phase did not enter the pipeline");

  a_no_emit_off_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode != phase)) |=> !v1)
    else $error("accepted item off phase entered the pipeline");

  a_phase_toggles: assert property (@(posedge clk) disable iff (rst)
    accept |=> (phase != $past(phase)))
    else $error("phase did not toggle on an accepted item");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && m_tvalid))
    else $error("input stalled while a pipeline stage was empty");

endmodule

`default_nettype wire
